>>> rtl/sha1_pkg.sv
// Shared types and constants of the SHA-1 hash engine.
package sha1_pkg;

    localparam int              Q_DEPTH_DEF = 4;
    localparam int              DIGEST_WORDS = 5;
    localparam logic [2:0]      LAST_IDX    = 3'd4;
    localparam logic [5:0]      LEN_POS     = 6'd56;
    localparam logic [5:0]      LAST_POS    = 6'd63;
    localparam logic [7:0]      PAD_BYTE    = 8'h80;
    localparam logic [6:0]      LAST_ROUND  = 7'd79;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] IV [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic MODE_FINISH = 1'b1;

    typedef enum logic {
        KIND_ABSORB = 1'b0,
        KIND_FINISH = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_req;

endpackage

>>> rtl/sha1_if.sv
// Request and digest channel interfaces of the SHA-1 hash engine.
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index, output last_word,
                    input ready);
    modport sink (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

>>> rtl/sha1_hash_engine.sv
// Top level of the SHA-1 hash engine.
//
//  channel  | dir | payload                                 | accepted when
//  i_in     | in  | mode, data_byte                         | valid && ready
//  o_out    | out | digest_word, word_index, last_word      | valid && ready
//
// An absorb request adds one byte to the block in the back end; every 64th byte
// starts a compression (80 rounds through the one round unit, then the chaining add).
// A finish feeds padding bytes at one a cycle to the block end, then one or two
// compressions, then five digest words. Reset loads the initial vector and a
// zero count, with no clearing pass. A queue of Q_DEPTH requests absorbs input
// while the back end is busy; the output register holds a word until the sink
// is ready.
module sha1_hash_engine #(
    parameter int Q_DEPTH = sha1_pkg::Q_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha1_in_if.sink    i_in,
    sha1_out_if.source o_out
);
    import sha1_pkg::*;

    t_req w_req;
    logic w_req_valid;
    logic w_req_pop;

    sha1_front #(
        .DEPTH(Q_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_req      (w_req),
        .o_req_valid(w_req_valid),
        .i_req_pop  (w_req_pop)
    );

    sha1_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_req_valid(w_req_valid),
        .o_req_pop  (w_req_pop),
        .o_out      (o_out)
    );

endmodule

>>> rtl/sha1_front.sv
// Front end: accept and classify requests into a short queue.
module sha1_front #(
    parameter int DEPTH = sha1_pkg::Q_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sha1_in_if.sink        i_in,
    output sha1_pkg::t_req o_req,
    output logic           o_req_valid,
    input  logic           i_req_pop
);
    import sha1_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_req             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;
    t_req             w_req;

    assign i_in.ready  = (r_count < CNT_W'(DEPTH));
    assign w_push      = i_in.valid && i_in.ready;
    assign o_req_valid = (r_count != '0);
    assign w_pop       = i_req_pop && o_req_valid;
    assign o_req       = r_mem[r_rd_ptr];

    always_comb begin
        w_req.kind = (i_in.mode == MODE_FINISH) ? KIND_FINISH : KIND_ABSORB;
        w_req.data = i_in.data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

>>> rtl/sha1_back.sv
// Back end: block assembly, padding, 80-round compression and digest output.
module sha1_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sha1_pkg::t_req i_req,
    input  logic           i_req_valid,
    output logic           o_req_pop,
    sha1_out_if.source     o_out
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FINAL,
        S_OUT
    } t_state;

    t_state      r_state;
    logic [63:0] r_count;
    logic [63:0] r_len;
    logic [23:0] r_acc;
    logic [31:0] r_w [16];
    logic [31:0] r_h [DIGEST_WORDS];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [6:0]  r_round;
    logic        r_fin;
    logic        r_pad_first;
    logic        r_len_ok;
    logic        r_done;
    logic [2:0]  r_idx;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_idx;
    logic        r_out_last;

    logic [5:0]  w_pos;
    logic [63:0] w_len_sh;
    logic [7:0]  w_pad_byte;
    logic        w_byte_en;
    logic [7:0]  w_byte;
    logic        w_shift_en;
    logic [31:0] w_sched_x;
    logic [31:0] w_shift_word;
    logic [31:0] w_f;
    logic [31:0] w_k;
    logic [31:0] w_t;
    logic [31:0] w_h_sel;
    logic        w_start;

    assign w_pos     = r_count[8:3];
    assign w_len_sh  = r_len << {w_pos[2:0], 3'b000};
    assign w_sched_x = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_t       = {r_a[26:0], r_a[31:27]} + w_f + r_e + r_w[0] + w_k;

    always_comb begin
        if (r_pad_first) begin
            w_pad_byte = PAD_BYTE;
        end else if (r_len_ok && (w_pos >= LEN_POS)) begin
            w_pad_byte = w_len_sh[63:56];
        end else begin
            w_pad_byte = '0;
        end
    end

    always_comb begin
        o_req_pop = 1'b0;
        w_byte_en = 1'b0;
        w_byte    = i_req.data;
        unique case (r_state)
            S_IDLE: begin
                o_req_pop = i_req_valid;
                w_byte_en = i_req_valid && (i_req.kind == KIND_ABSORB);
            end
            S_PAD: begin
                w_byte_en = 1'b1;
                w_byte    = w_pad_byte;
            end
            default: begin
                w_byte_en = 1'b0;
            end
        endcase
    end

    assign w_start      = w_byte_en && (w_pos == LAST_POS);
    assign w_shift_en   = (w_byte_en && (w_pos[1:0] == 2'b11)) || (r_state == S_ROUND);
    assign w_shift_word = (r_state == S_ROUND) ? {w_sched_x[30:0], w_sched_x[31]}
                                                : {r_acc, w_byte};

    always_comb begin
        priority if (r_round < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K0;
        end else if (r_round < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (r_round < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
    end

    always_comb begin
        unique case (r_idx)
            3'd0:    w_h_sel = r_h[0];
            3'd1:    w_h_sel = r_h[1];
            3'd2:    w_h_sel = r_h[2];
            3'd3:    w_h_sel = r_h[3];
            3'd4:    w_h_sel = r_h[4];
            default: w_h_sel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_h         <= IV;
            r_fin       <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_done      <= 1'b0;
            r_idx       <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            if (w_byte_en) begin
                r_count <= r_count + 64'd8;
                r_acc   <= {r_acc[15:0], w_byte};
            end
            if (w_shift_en) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i+1];
                end
                r_w[15] <= w_shift_word;
            end
            if (w_start) begin
                r_a     <= r_h[0];
                r_b     <= r_h[1];
                r_c     <= r_h[2];
                r_d     <= r_h[3];
                r_e     <= r_h[4];
                r_round <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid && (i_req.kind == KIND_FINISH)) begin
                        r_fin       <= 1'b1;
                        r_pad_first <= 1'b1;
                        r_len_ok    <= 1'b0;
                        r_len       <= r_count;
                        r_state     <= S_PAD;
                    end else if (w_start) begin
                        r_state <= S_ROUND;
                    end
                end
                S_PAD: begin
                    r_pad_first <= 1'b0;
                    if (w_start) begin
                        r_len_ok <= 1'b1;
                        r_done   <= r_len_ok;
                        r_state  <= S_ROUND;
                    end else if (r_pad_first) begin
                        r_len_ok <= (w_pos < LEN_POS);
                    end
                end
                S_ROUND: begin
                    r_a     <= w_t;
                    r_b     <= r_a;
                    r_c     <= {r_b[1:0], r_b[31:2]};
                    r_d     <= r_c;
                    r_e     <= r_d;
                    r_round <= r_round + 1'b1;
                    if (r_round == LAST_ROUND) begin
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_h[0] <= r_h[0] + r_a;
                    r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c;
                    r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_idx  <= '0;
                    if (!r_fin) begin
                        r_state <= S_IDLE;
                    end else if (r_done) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PAD;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= w_h_sel;
                        r_out_idx   <= r_idx;
                        r_out_last  <= (r_idx == LAST_IDX);
                        if (r_idx == LAST_IDX) begin
                            r_h     <= IV;
                            r_count <= '0;
                            r_fin   <= 1'b0;
                            r_done  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.digest_word = r_out_word;
    assign o_out.word_index  = r_out_idx;
    assign o_out.last_word   = r_out_last;

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_round <= LAST_ROUND))
        else $error("round counter out of range");

    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_last == (r_out_idx == LAST_IDX)))
        else $error("last word flag disagrees with word index");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_pop |-> (r_state == S_IDLE))
        else $error("request taken while busy");

    a_done_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_fin)
        else $error("final block marked outside a finish");

endmodule

>>> dv/tb_sha1_hash_engine.sv
// Self-checking testbench of the SHA-1 hash engine: random-gapped byte stream, digest check.
module tb_sha1_hash_engine;
    import sha1_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sha1_in_if  in_if ();
    sha1_out_if out_if ();

    sha1_hash_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [31:0] hash_state [DIGEST_WORDS];
    logic [7:0]  msg_block [64];
    logic [63:0] msg_bits;
    t_digest     digest_q [$];

    int  errors     = 0;
    int  cycle_cnt  = 0;
    int  sink_hold  = 0;
    bit  src_idle_on  = 1'b1;
    bit  sink_idle_on = 1'b1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void sha1_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
            w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
        for (int r = 16; r < 80; r++) begin
            t    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {t[30:0], t[31]};
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        for (int r = 0; r < 80; r++) begin
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + w[r] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
    endfunction

    function automatic void predict_request(input t_kind kind, input logic [7:0] b);
        int      pos;
        t_digest item;
        pos = msg_bits[8:3];
        if (kind != KIND_FINISH) begin
            msg_block[pos] = b;
            msg_bits += 64'd8;
            if (pos == LAST_POS)
                sha1_compress();
        end else begin
            msg_block[pos] = PAD_BYTE;
            pos++;
            if (pos > LEN_POS) begin
                for (int i = pos; i < 64; i++)
                    msg_block[i] = 8'h00;
                sha1_compress();
                for (int i = 0; i < LEN_POS; i++)
                    msg_block[i] = 8'h00;
            end else begin
                for (int i = pos; i < LEN_POS; i++)
                    msg_block[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++)
                msg_block[LEN_POS + i] = msg_bits[63 - 8*i -: 8];
            sha1_compress();
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                item.word = hash_state[i];
                item.idx  = 3'(i);
                item.last = (3'(i) == LAST_IDX);
                digest_q.push_back(item);
            end
            hash_state = IV;
            msg_bits   = 64'd0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycle_cnt);
        errors++;
    endtask

    always @(posedge i_clk) begin : check_digest
        t_digest want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected digest word", out_if.digest_word, 32'h0);
            end else begin
                want = digest_q.pop_front();
                if (out_if.digest_word !== want.word)
                    report_mismatch("digest_word", out_if.digest_word, want.word);
                if (out_if.word_index !== want.idx)
                    report_mismatch("word_index", 32'(out_if.word_index), 32'(want.idx));
                if (out_if.last_word !== want.last)
                    report_mismatch("last_word", 32'(out_if.last_word), 32'(want.last));
            end
        end
    end

    always @(negedge i_clk) begin
        if (sink_hold > 0)
            sink_hold--;
        else if (sink_idle_on && $urandom_range(0, 5) == 0)
            sink_hold = $urandom_range(1, 19);
        out_if.ready <= (sink_hold == 0);
    end

    // Enter and leave at a falling edge; valid stays high for a following request.
    task automatic send_req(input t_kind kind, input logic [7:0] b);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.mode      <= kind;
        in_if.data_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        predict_request(kind, b);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_req(KIND_ABSORB, 8'($urandom_range(0, 255)));
        send_req(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_empty_message();
        send_req(KIND_FINISH, 8'h00);
        send_req(KIND_FINISH, 8'hFF);
    endtask

    task automatic test_byte_extremes();
        send_req(KIND_ABSORB, 8'h00);
        send_req(KIND_ABSORB, 8'hFF);
        send_req(KIND_ABSORB, 8'h80);
        send_req(KIND_ABSORB, 8'h7F);
        send_req(KIND_ABSORB, 8'h01);
        send_req(KIND_ABSORB, 8'hFE);
        send_req(KIND_FINISH, 8'h55);
        send_req(KIND_ABSORB, 8'h61);
        send_req(KIND_ABSORB, 8'h62);
        send_req(KIND_ABSORB, 8'h63);
        send_req(KIND_FINISH, 8'hAA);
    endtask

    task automatic test_block_boundaries();
        send_message(55);
        send_message(56);
        send_message(64);
    endtask

    task automatic test_random_stream(input int n_items);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_req(KIND_FINISH, 8'($urandom_range(0, 255)));
            else
                send_req(KIND_ABSORB, 8'($urandom_range(0, 255)));
        end
        send_req(KIND_FINISH, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_back_to_back();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_message($urandom_range(10, 30));
        send_req(KIND_FINISH, 8'h00);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.mode      = KIND_ABSORB;
        in_if.data_byte = 8'h00;
        out_if.ready    = 1'b0;
        hash_state      = IV;
        msg_bits        = 64'd0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_message();
        test_byte_extremes();
        test_block_boundaries();
        test_random_stream(120);
        test_back_to_back();

        in_if.valid <= 1'b0;
        wait (digest_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sha1_hash_engine.f
rtl/sha1_pkg.sv
rtl/sha1_if.sv
rtl/sha1_front.sv
rtl/sha1_back.sv
rtl/sha1_hash_engine.sv
dv/tb_sha1_hash_engine.sv
